// ===== rtl/r8k_pkg.sv =====
// Shared types, constants and helper functions for the ROT8000 UTF-8 stream core.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package r8k_pkg;

    localparam int unsigned CpWidth   = 21;
    localparam int unsigned TokDepth  = 2;

    localparam logic [CpWidth-1:0] RotLow   = 21'h000021;
    localparam logic [CpWidth-1:0] RotHigh  = 21'h007E7D;
    localparam logic [14:0]        RotOfs   = 15'h0021;
    localparam logic [14:0]        RotHalf  = 15'h4000;
    localparam logic [CpWidth-1:0] CpMax    = 21'h10FFFF;
    localparam logic [CpWidth-1:0] Max1Byte = 21'h00007F;
    localparam logic [CpWidth-1:0] Max2Byte = 21'h0007FF;
    localparam logic [CpWidth-1:0] Max3Byte = 21'h00FFFF;

    // Byte count of an encoded token, minus one.
    typedef enum logic [1:0] {
        LEN1 = 2'd0,
        LEN2 = 2'd1,
        LEN3 = 2'd2,
        LEN4 = 2'd3
    } enc_len_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       output_end;
    } out_item_t;

    // One code point (or raw byte, or bare end marker) waiting to be encoded.
    typedef struct packed {
        logic [CpWidth-1:0] value;
        enc_len_t           len;
        logic               byte_valid;
        logic               run_last;
        logic               output_end;
    } token_t;

    // Sequence length a lead byte calls for; 0 for a stray byte.
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        if (b[7] == 1'b0)
            len = 3'd1;
        else if (b[7:5] == 3'b110)
            len = 3'd2;
        else if (b[7:4] == 4'b1110)
            len = 3'd3;
        else if (b[7:3] == 5'b11110)
            len = 3'd4;
        else
            len = 3'd0;
        return len;
    endfunction

    // Byte number idx of the UTF-8 form of a token.
    function automatic logic [7:0] enc_byte(input logic [CpWidth-1:0] v,
                                            input enc_len_t len,
                                            input logic [1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        unique case (len)
            LEN1: b = v[7:0];
            LEN2:
            begin
                if (idx == 2'd0)
                    b = {3'b110, v[10:6]};
                else
                    b = {2'b10, v[5:0]};
            end
            LEN3:
            begin
                if (idx == 2'd0)
                    b = {4'b1110, v[15:12]};
                else if (idx == 2'd1)
                    b = {2'b10, v[11:6]};
                else
                    b = {2'b10, v[5:0]};
            end
            LEN4:
            begin
                if (idx == 2'd0)
                    b = {5'b11110, v[20:18]};
                else if (idx == 2'd1)
                    b = {2'b10, v[17:12]};
                else if (idx == 2'd2)
                    b = {2'b10, v[11:6]};
                else
                    b = {2'b10, v[5:0]};
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/r8k_front.sv =====
// Front part: takes input bytes, holds unfinished sequences, and turns each
// closed buffer into tokens one per cycle, queue permitting. Depends on r8k_pkg.
`default_nettype none

module r8k_front
    import r8k_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire in_item_t item,
    output logic          full,
    input  wire logic     tok_ready,
    output logic          tok_push,
    output token_t        tok
);

    logic [7:0] held_reg [3];
    logic [1:0] held_cnt_reg;
    logic [7:0] wbuf_reg [4];
    logic [2:0] wn_reg;
    logic       wlast_reg;
    logic       wbusy_reg;

    logic [7:0] buf_in [4];
    logic [2:0] n_in;
    logic [2:0] len_in;
    logic       hold;
    logic       acc;

    logic [2:0]         len;
    logic               take_raw;
    logic [2:0]         used;
    logic [2:0]         rem;
    logic               done;
    logic [CpWidth-1:0] cp;
    logic [14:0]        rot_t;
    logic [CpWidth-1:0] rot;
    logic               drop;
    logic               emit;
    logic               step;

    // Build the closed buffer: held bytes, then the new byte.
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            if (j < 3 && 2'(j) != held_cnt_reg)
                buf_in[j] = held_reg[j < 3 ? j : 0];
            else
                buf_in[j] = item.data_byte;
        end
        n_in   = {1'b0, held_cnt_reg} + 3'd1;
        len_in = lead_len(buf_in[0]);
        hold   = !item.stream_end && len_in != 3'd0 && n_in < len_in;
    end

    // Parse step on the head of the work buffer.
    always_comb
    begin
        len      = lead_len(wbuf_reg[0]);
        take_raw = (len == 3'd0) || (len > wn_reg);
        used     = take_raw ? 3'd1 : len;
        rem      = wn_reg - used;
        done     = (rem == 3'd0);

        unique case (len)
            3'd2:    cp = {10'd0, wbuf_reg[0][4:0], wbuf_reg[1][5:0]};
            3'd3:    cp = {5'd0, wbuf_reg[0][3:0], wbuf_reg[1][5:0], wbuf_reg[2][5:0]};
            3'd4:    cp = {wbuf_reg[0][2:0], wbuf_reg[1][5:0], wbuf_reg[2][5:0],
                           wbuf_reg[3][5:0]};
            default: cp = {13'd0, wbuf_reg[0]};
        endcase

        rot_t = cp[14:0] - RotOfs + RotHalf;
        if (cp >= RotLow && cp <= RotHigh)
            rot = {6'd0, rot_t} + RotLow;
        else
            rot = cp;

        drop = !take_raw && (rot > CpMax);
        emit = !drop || (done && wlast_reg);

        tok.run_last   = done;
        tok.output_end = done && wlast_reg;
        if (take_raw)
        begin
            tok.value      = {13'd0, wbuf_reg[0]};
            tok.len        = LEN1;
            tok.byte_valid = 1'b1;
        end
        else if (drop)
        begin
            tok.value      = '0;
            tok.len        = LEN1;
            tok.byte_valid = 1'b0;
        end
        else
        begin
            tok.value      = rot;
            tok.byte_valid = 1'b1;
            if (rot <= Max1Byte)
                tok.len = LEN1;
            else if (rot <= Max2Byte)
                tok.len = LEN2;
            else if (rot <= Max3Byte)
                tok.len = LEN3;
            else
                tok.len = LEN4;
        end

        step     = wbusy_reg && (!emit || tok_ready);
        tok_push = wbusy_reg && emit && tok_ready;
        full     = wbusy_reg && !(step && done);
        acc      = push && !full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cnt_reg <= 2'd0;
            wn_reg       <= 3'd0;
            wlast_reg    <= 1'b0;
            wbusy_reg    <= 1'b0;
            for (int j = 0; j < 3; j++)
                held_reg[j] <= 8'h00;
            for (int j = 0; j < 4; j++)
                wbuf_reg[j] <= 8'h00;
        end
        else
        begin
            if (acc && !hold)
            begin
                // load a closed buffer; the previous one finishes this cycle
                held_cnt_reg <= 2'd0;
                for (int j = 0; j < 4; j++)
                    wbuf_reg[j] <= buf_in[j];
                wn_reg    <= n_in;
                wlast_reg <= item.stream_end;
                wbusy_reg <= 1'b1;
            end
            else
            begin
                if (acc)
                begin
                    for (int j = 0; j < 3; j++)
                        held_reg[j] <= buf_in[j];
                    held_cnt_reg <= n_in[1:0];
                end
                if (step)
                begin
                    // advance past the consumed bytes
                    unique case (used)
                        3'd1:
                        begin
                            wbuf_reg[0] <= wbuf_reg[1];
                            wbuf_reg[1] <= wbuf_reg[2];
                            wbuf_reg[2] <= wbuf_reg[3];
                        end
                        3'd2:
                        begin
                            wbuf_reg[0] <= wbuf_reg[2];
                            wbuf_reg[1] <= wbuf_reg[3];
                        end
                        3'd3:    wbuf_reg[0] <= wbuf_reg[3];
                        default: wbuf_reg[0] <= wbuf_reg[0];
                    endcase
                    wn_reg <= rem;
                    if (done)
                        wbusy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/r8k_queue.sv =====
// Short token queue between the front and back parts.
// Depends on r8k_pkg for the token type and depth.
`default_nettype none

module r8k_queue
    import r8k_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   wr_en,
    input  wire token_t wr_tok,
    output logic        ready,
    input  wire logic   rd_en,
    output token_t      head,
    output logic        valid
);

    localparam int unsigned PtrW = $clog2(TokDepth);

    token_t            mem_reg [TokDepth];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [PtrW:0]     count_reg;
    logic              do_wr;
    logic              do_rd;

    assign ready = (count_reg < (PtrW+1)'(TokDepth));
    assign valid = (count_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];
    assign do_wr = wr_en && ready;
    assign do_rd = rd_en && valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_tok;
    end

endmodule

`default_nettype wire

// ===== rtl/r8k_back.sv =====
// Back part: encodes queued tokens as UTF-8 into the result register, one
// byte per cycle while that register is free or popped. Depends on r8k_pkg.
`default_nettype none

module r8k_back
    import r8k_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire token_t head,
    input  wire logic   head_valid,
    output logic        head_pop,
    input  wire logic   pop,
    output logic        empty,
    output out_item_t   result
);

    out_item_t  out_reg;
    logic       ovalid_reg;
    logic [1:0] idx_reg;
    logic       slot;
    logic       fire;
    logic       final_byte;

    assign slot       = !ovalid_reg || pop;
    assign fire       = head_valid && slot;
    assign final_byte = (idx_reg == head.len);
    assign head_pop   = fire && final_byte;
    assign empty      = !ovalid_reg;
    assign result     = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            idx_reg    <= 2'd0;
        end
        else
        begin
            if (fire)
                ovalid_reg <= 1'b1;
            else if (pop)
                ovalid_reg <= 1'b0;
            if (fire)
                idx_reg <= final_byte ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg.out_byte   <= enc_byte(head.value, head.len, idx_reg);
            out_reg.byte_valid <= head.byte_valid;
            out_reg.run_last   <= head.run_last && final_byte;
            out_reg.output_end <= head.output_end && final_byte;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rot8000_utf8_stream_core.sv =====
// Top level of the ROT8000 UTF-8 stream core: front parser, token queue and
// byte encoder. Depends on r8k_pkg, r8k_front, r8k_queue and r8k_back.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  input    | push / full          | item   (data_byte, stream_end)
//  result   | empty / pop          | result (out_byte, byte_valid, run_last,
//           |                      |         output_end)
//
// The front takes one byte per cycle unless full and turns a closed sequence
// into a token; a stream end with an incomplete sequence parses one token per
// cycle while the queue has room, up to three. The back emits one output byte
// per cycle while its result slot is free; an item yields 0 to 7 bytes, 3 for
// rotated ASCII. Reset is asynchronous and needs no clearing pass. A two-entry
// token queue lets the parser run ahead while the result side stalls on pop.
`default_nettype none

module rot8000_utf8_stream_core
    import r8k_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t item,
    output logic          empty,
    input  wire logic     pop,
    output out_item_t     result
);

    // tokens from the parser into the queue
    token_t tok;
    logic   tok_push;
    logic   tok_ready;

    // queue head toward the encoder
    token_t head;
    logic   head_valid;
    logic   head_pop;

    // Hold partial sequences, classify bytes, and emit code-point tokens.
    r8k_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .tok_ready (tok_ready),
        .tok_push  (tok_push),
        .tok       (tok)
    );

    // Decouple the parser from the encoder.
    r8k_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (tok_push),
        .wr_tok (tok),
        .ready  (tok_ready),
        .rd_en  (head_pop),
        .head   (head),
        .valid  (head_valid)
    );

    // Encode each token as UTF-8 and drive the result register.
    r8k_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

    // the end of the stream always closes the run of the final item
    a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.output_end |-> result.run_last)
        else $error("output_end without run_last");

    // a bare end marker only ever appears as the last result of a stream
    a_bare_marker_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !result.byte_valid |-> result.output_end)
        else $error("bare marker not at stream end");

    // an end-of-stream token is always the last token of its item
    a_tok_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        tok_push && tok.output_end |-> tok.run_last)
        else $error("end token not last of its item");

endmodule

`default_nettype wire

// ===== verif/rot8000_utf8_checker.sv =====
// Scoreboard for the ROT8000 UTF-8 stream core: predicts the result items of
// every accepted input item and compares them with what the core hands out.
// Depends on r8k_pkg for the item and result types.

module rot8000_utf8_checker
    import r8k_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  logic      full,
    input  in_item_t  item,
    input  logic      empty,
    input  logic      pop,
    input  out_item_t result,
    output int        mismatches,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Bytes of an unfinished sequence, lead first, and how many there are.
    logic [7:0] held_seq [0:2];
    int         held_n;

    out_item_t  expected_bytes [$];
    out_item_t  step_bytes [0:6];
    int         step_n;

    function automatic int seq_length(input logic [7:0] b);
        if (!b[7])
            return 1;
        if (b[7:5] == 3'b110)
            return 2;
        if (b[7:4] == 4'b1110)
            return 3;
        if (b[7:3] == 5'b11110)
            return 4;
        return 0;
    endfunction

    // Continuation bytes are masked to their low six bits, never checked.
    function automatic logic [20:0] decode_cp(input logic [7:0] b0, input logic [7:0] b1,
                                              input logic [7:0] b2, input logic [7:0] b3,
                                              input int len);
        case (len)
            1: return 21'(b0);
            2: return 21'({b0[4:0], b1[5:0]});
            3: return 21'({b0[3:0], b1[5:0], b2[5:0]});
            default: return {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
        endcase
    endfunction

    task automatic put_byte(input logic [7:0] b);
        step_bytes[step_n] = '{out_byte: b, byte_valid: 1'b1, run_last: 1'b0,
                               output_end: 1'b0};
        step_n++;
    endtask

    // Rotate one code point and re-encode it; above 0x10FFFF nothing comes out.
    task automatic put_cp(input logic [20:0] cp);
        logic [31:0] v;
        v = 32'(cp);
        if (v >= 32'h21 && v <= 32'h7E7D)
            v = ((v - 32'h21 + 32'h4000) % 32'h8000) + 32'h21;
        if (v <= 32'h7F)
        begin
            put_byte(v[7:0]);
        end
        else if (v <= 32'h7FF)
        begin
            put_byte({3'b110, v[10:6]});
            put_byte({2'b10, v[5:0]});
        end
        else if (v <= 32'hFFFF)
        begin
            put_byte({4'b1110, v[15:12]});
            put_byte({2'b10, v[11:6]});
            put_byte({2'b10, v[5:0]});
        end
        else if (v <= 32'h10FFFF)
        begin
            put_byte({5'b11110, v[20:18]});
            put_byte({2'b10, v[17:12]});
            put_byte({2'b10, v[11:6]});
            put_byte({2'b10, v[5:0]});
        end
    endtask

    task automatic rot8000_step(input in_item_t it);
        logic [7:0] seq [0:6];
        int n;
        int i;
        int len;
        step_n = 0;
        for (i = 0; i < 7; i++)
            seq[i] = (i < 3) ? held_seq[i] : 8'h00;
        n = held_n;
        seq[n] = it.data_byte;
        n++;
        if (it.stream_end)
        begin
            // Close the stream: parse what is held from the start again.
            i = 0;
            while (i < n)
            begin
                len = seq_length(seq[i]);
                if (len == 0 || i + len > n)
                begin
                    put_byte(seq[i]);
                    i++;
                end
                else
                begin
                    put_cp(decode_cp(seq[i], seq[i+1], seq[i+2], seq[i+3], len));
                    i += len;
                end
            end
            held_n = 0;
            if (step_n == 0)
            begin
                step_bytes[0] = '0;
                step_n = 1;
            end
            step_bytes[step_n-1].run_last = 1'b1;
            step_bytes[step_n-1].output_end = 1'b1;
        end
        else
        begin
            len = seq_length(seq[0]);
            if (len == 0)
            begin
                put_byte(seq[0]);
                held_n = 0;
            end
            else if (n >= len)
            begin
                put_cp(decode_cp(seq[0], seq[1], seq[2], seq[3], len));
                held_n = 0;
            end
            else
            begin
                for (i = 0; i < 3; i++)
                    held_seq[i] = seq[i];
                held_n = n;
            end
            if (step_n > 0)
                step_bytes[step_n-1].run_last = 1'b1;
        end
        for (i = 0; i < step_n; i++)
            expected_bytes.insert(expected_bytes.size(), step_bytes[i]);
    endtask

    task automatic report(input string field, input logic [7:0] exp_v, input logic [7:0] got_v);
        $display("%0t: %s mismatch, expected %02h, actual %02h", $time, field, exp_v, got_v);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        out_item_t exp_r;
        if (!rst_n)
        begin
            held_seq = '{default: 8'h00};
            held_n = 0;
            expected_bytes.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            if (push && !full)
                rot8000_step(item);
            if (pop && !empty)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %02h/%b/%b/%b",
                             $time, result.out_byte, result.byte_valid, result.run_last,
                             result.output_end);
                    mismatches++;
                end
                else
                begin
                    exp_r = expected_bytes.pop_front();
                    if (result.out_byte !== exp_r.out_byte)
                        report("out_byte", exp_r.out_byte, result.out_byte);
                    if (result.byte_valid !== exp_r.byte_valid)
                        report("byte_valid", 8'(exp_r.byte_valid), 8'(result.byte_valid));
                    if (result.run_last !== exp_r.run_last)
                        report("run_last", 8'(exp_r.run_last), 8'(result.run_last));
                    if (result.output_end !== exp_r.output_end)
                        report("output_end", 8'(exp_r.output_end), 8'(result.output_end));
                end
            end
            pending = expected_bytes.size();
        end
    end

endmodule

// ===== verif/tb_rot8000_utf8_stream_core.sv =====
// Testbench top for the ROT8000 UTF-8 stream core: drives byte items, pops
// results with random stalls and reports the verdict.
// Depends on r8k_pkg, rot8000_utf8_stream_core and rot8000_utf8_checker.

module tb_rot8000_utf8_stream_core;
    import r8k_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Kinds of byte sequence that the random part builds.
    typedef enum int {
        SEQ_ASCII,
        SEQ_TWO,
        SEQ_THREE,
        SEQ_FOUR,
        SEQ_STRAY
    } seq_kind_t;

    localparam int RandomItems = 248;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      pop = 1'b0;
    in_item_t  item = '0;
    logic      full;
    logic      empty;
    out_item_t result;
    int        mismatches;
    int        pending;

    // Percent of cycles in which each side sits idle; zero during the calm stretch.
    int        idle_pct = 19;
    int        sent = 0;

    always #2 clk = ~clk;

    rot8000_utf8_stream_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    rot8000_utf8_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Result side: stall pop at random, change it only on the falling edge.
    always @(negedge clk)
        pop <= rst_n && ($urandom_range(99) >= idle_pct);

    // Offer one item and hold it until the core takes it. Entered and left on
    // a falling edge, so push and item only ever move there.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        item <= '{data_byte: b, stream_end: last};
        do
            @(posedge clk);
        while (full);
        @(negedge clk);
        sent++;
    endtask

    // Hold the sender until every predicted result has been popped.
    task automatic wait_drained();
        push <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    // Build one sequence with random content; now and then cut it short or
    // close the stream on its last byte.
    task automatic send_sequence(input seq_kind_t kind);
        logic [7:0] seq [0:3];
        int len;
        int stop;
        int i;
        logic close;
        len = 1;
        case (kind)
            SEQ_ASCII:
                seq[0] = 8'($urandom_range(0, 127));
            SEQ_TWO:
            begin
                seq[0] = 8'hC0 | 8'($urandom_range(0, 31));
                len = 2;
            end
            SEQ_THREE:
            begin
                seq[0] = 8'hE0 | 8'($urandom_range(0, 15));
                len = 3;
            end
            SEQ_FOUR:
            begin
                seq[0] = 8'hF0 | 8'($urandom_range(0, 7));
                len = 4;
            end
            default:
                seq[0] = ($urandom_range(1) == 0) ? 8'h80 | 8'($urandom_range(0, 63))
                                                   : 8'hF8 | 8'($urandom_range(0, 7));
        endcase
        // Continuations are not checked by the core, so let some carry any top bits.
        for (i = 1; i < len; i++)
            seq[i] = ($urandom_range(99) < 85) ? 8'h80 | 8'($urandom_range(0, 63))
                                               : 8'($urandom_range(0, 255));
        stop = len;
        if (len > 1 && $urandom_range(99) < 8)
            stop = $urandom_range(1, len - 1);
        close = ($urandom_range(99) < 9);
        for (i = 0; i < stop; i++)
            send_byte(seq[i], close && (i == stop - 1));
    endtask

    function automatic seq_kind_t pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            return SEQ_ASCII;
        if (r < 50)
            return SEQ_TWO;
        if (r < 80)
            return SEQ_THREE;
        if (r < 92)
            return SEQ_FOUR;
        return SEQ_STRAY;
    endfunction

    initial
    begin
        int start;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: edges of the rotated range and of each encoding length.
        send_byte(8'h00, 1'b0);             // below the range, passes
        send_byte(8'h21, 1'b0);             // first rotated code point
        send_byte(8'h7F, 1'b0);             // top ASCII, rotated to three bytes
        send_byte(8'hC2, 1'b0);             // two-byte sequence
        send_byte(8'hA9, 1'b0);
        send_byte(8'hE7, 1'b0);             // 0x7E7D, last rotated code point
        send_byte(8'hB9, 1'b0);
        send_byte(8'hBD, 1'b0);
        send_byte(8'hF0, 1'b0);             // four-byte code point, passes
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);             // stray continuation, copied raw
        send_byte(8'hFF, 1'b0);             // stray high byte, copied raw
        send_byte(8'hE3, 1'b0);             // completed by the stream end:
        send_byte(8'h81, 1'b0);             // continuation unchecked, one code point
        send_byte(8'h41, 1'b1);
        send_byte(8'hF4, 1'b0);             // beyond 0x10FFFF at stream end:
        send_byte(8'h90, 1'b0);             // nothing encoded, bare end marker
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'hF8, 1'b1);             // lone stray closing a stream

        // Let the core run dry before the random part.
        wait_drained();

        start = sent;
        while (sent < start + RandomItems)
        begin
            // Calm stretch: neither side idles.
            idle_pct = (sent - start >= 90 && sent - start < 160) ? 0 : 19;
            if (sent - start >= 200 && sent - start < 204)
                wait_drained();
            send_sequence(pick_kind());
        end
        idle_pct = 19;

        wait_drained();
        repeat (32) @(negedge clk);
        if (mismatches == 0)
            $display("tb_rot8000_utf8_stream_core OK");
        else
            $display("tb_rot8000_utf8_stream_core NOT OK");
        $finish;
    end

    // Give up on a hung core.
    initial
    begin
        #2_000_000;
        $display("tb_rot8000_utf8_stream_core NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/r8k_pkg.sv
rtl/r8k_front.sv
rtl/r8k_queue.sv
rtl/r8k_back.sv
rtl/rot8000_utf8_stream_core.sv
verif/rot8000_utf8_checker.sv
verif/tb_rot8000_utf8_stream_core.sv
